@@ rtl/lswa_pkg.sv @@
// Package for the laser scan wander avoidance unit.
// Holds the fixed constants, the drive mode codes and the register indexes.
// No dependencies.
package lswa_pkg;

  typedef logic [1:0] drive_mode_t;
  typedef logic [2:0] cfg_index_t;

  // Drive modes
  localparam drive_mode_t MODE_FORWARD = 2'd0;
  localparam drive_mode_t MODE_START   = 2'd1;
  localparam drive_mode_t MODE_TURN    = 2'd2;

  // Register indexes
  localparam cfg_index_t REG_SCAN_LENGTH = 3'd0;
  localparam cfg_index_t REG_WALL_THRESH = 3'd1;
  localparam cfg_index_t REG_STOP_THRESH = 3'd2;
  localparam cfg_index_t REG_AVOID_TIME  = 3'd3;
  localparam cfg_index_t REG_MOVE_RATE   = 3'd4;
  localparam cfg_index_t REG_TURN_RATE   = 3'd5;
  localparam cfg_index_t REG_RANDOM_SEED = 3'd6;

  // Register reset values
  localparam logic [10:0] RST_SCAN_LENGTH = 11'd360;
  localparam logic [15:0] RST_WALL_THRESH = 16'd800;
  localparam logic [15:0] RST_STOP_THRESH = 16'd200;
  localparam logic [7:0]  RST_AVOID_TIME  = 8'd10;
  localparam logic [15:0] RST_MOVE_RATE   = 16'd700;
  localparam logic [15:0] RST_TURN_RATE   = 16'd1000;
  localparam logic [15:0] RST_RANDOM_SEED = 16'd44257;

  // Scan and LFSR constants
  localparam logic [15:0] START_MIN = 16'd5000;
  localparam logic [10:0] INDEX_MAX = 11'd2047;
  localparam logic [15:0] LFSR_MASK = 16'hB400;

  // Reciprocal of three, scaled by 2^12, exact for lengths up to 2047
  localparam logic [10:0] THIRD_RECIP = 11'd1366;
  localparam int          THIRD_SHIFT = 12;

endpackage

@@ rtl/laser_scan_wander_avoidance_unit.sv @@
// Top level of the laser scan wander avoidance unit.
// Per-scan minimum and flag tracking, drive decision and an iterative modulo unit.
// Depends on lswa_pkg.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+--------------------------------------
//   in_     | input     | in_valid/in_ready  | range_mm, last_sample
//   out_    | output    | out_valid/out_ready| speed, rate, mode, minimums, flags
//   cfg_    | input     | cfg_we             | cfg_index, cfg_data
//
// A sample that is not the last of its scan is folded in as it is taken. The last
// sample closes the scan and goes to S_FIN, by way of S_DIV when a turn starts: the
// restoring divider there retires one bit of the 16-bit LFSR value per cycle to form
// the remainder by avoid_time. Reset is synchronous and needs no clearing pass.
// A result waiting in the output register holds only the end of the next scan;
// samples before the last keep flowing in.
module laser_scan_wander_avoidance_unit
  import lswa_pkg::*;
#(
  parameter int MAX_SAMPLES = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        in_range_mm,
  input  logic               in_last_sample,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        out_linear_speed,
  output logic signed [16:0] out_angular_rate,
  output logic [1:0]         out_drive_mode,
  output logic [15:0]        out_min_left,
  output logic [15:0]        out_min_right,
  output logic               out_blocked,
  output logic               out_too_close,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  localparam logic [3:0] DIV_LAST = 4'd15;

  // Configuration registers
  logic [10:0] scan_length_r;
  logic [15:0] wall_thresh_r, stop_thresh_r, move_rate_r, turn_rate_r;
  logic [7:0]  avoid_time_r;

  // Scan and drive state
  logic [1:0]  state_r;
  logic [10:0] index_r;
  logic [15:0] min_left_r, min_right_r;
  logic        blocked_r, close_r, turn_neg_r;
  logic [8:0]  counter_r;
  logic [15:0] lfsr_r;

  // Divider
  logic [15:0] dvd_r;
  logic [7:0]  rem_r;
  logic [3:0]  div_cnt_r;

  // Pending result
  logic [15:0]        res_lin_r, res_min_left_r, res_min_right_r;
  logic signed [16:0] res_ang_r;
  drive_mode_t        res_mode_r;
  logic               res_blocked_r, res_close_r;

  logic out_valid_r;

  // Effective length, thirds and halves
  logic [10:0] eff_len;
  logic [21:0] third_prod;
  logic [10:0] sector, half;
  logic        in_middle;
  logic        take;
  logic        blk_upd, cls_upd;
  logic [15:0] left_upd, right_upd;
  logic        avoid;
  logic [15:0] lfsr_adv;
  logic [8:0]  trial;
  logic        out_free;

  assign eff_len    = (32'(scan_length_r) > MAX_SAMPLES) ? 11'(MAX_SAMPLES) : scan_length_r;
  assign third_prod = eff_len * THIRD_RECIP;
  assign sector     = 11'(third_prod >> THIRD_SHIFT);
  assign half       = {1'b0, eff_len[10:1]};
  assign in_middle  = (index_r > sector) && (index_r < (eff_len - sector));

  assign in_ready = (state_r == S_IDLE);
  assign take     = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // Fold this sample into the scan state
  always_comb begin
    blk_upd   = blocked_r || (in_middle && (in_range_mm < wall_thresh_r));
    cls_upd   = close_r || (in_range_mm < stop_thresh_r);
    left_upd  = min_left_r;
    right_upd = min_right_r;
    if (index_r > half) begin
      if (in_range_mm < min_right_r) right_upd = in_range_mm;
    end else begin
      if (in_range_mm < min_left_r) left_upd = in_range_mm;
    end
  end

  assign avoid    = blk_upd || cls_upd || (counter_r != 9'd0);
  assign lfsr_adv = lfsr_r[0] ? ((lfsr_r >> 1) ^ LFSR_MASK) : (lfsr_r >> 1);
  assign trial    = {rem_r, dvd_r[15]};

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_length_r <= RST_SCAN_LENGTH;
      wall_thresh_r <= RST_WALL_THRESH;
      stop_thresh_r <= RST_STOP_THRESH;
      avoid_time_r  <= RST_AVOID_TIME;
      move_rate_r   <= RST_MOVE_RATE;
      turn_rate_r   <= RST_TURN_RATE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCAN_LENGTH: scan_length_r <= cfg_data[10:0];
        REG_WALL_THRESH: wall_thresh_r <= cfg_data;
        REG_STOP_THRESH: stop_thresh_r <= cfg_data;
        REG_AVOID_TIME:  avoid_time_r  <= cfg_data[7:0];
        REG_MOVE_RATE:   move_rate_r   <= cfg_data;
        REG_TURN_RATE:   turn_rate_r   <= cfg_data;
        // The seed goes straight into the LFSR in the sequencer
        REG_RANDOM_SEED: ;
        default: ;
      endcase
    end
  end

  // Sequencer, scan state, drive state and divider
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      index_r     <= '0;
      min_left_r  <= START_MIN;
      min_right_r <= START_MIN;
      blocked_r   <= 1'b0;
      close_r     <= 1'b0;
      turn_neg_r  <= 1'b0;
      counter_r   <= '0;
      lfsr_r      <= RST_RANDOM_SEED;
      out_valid_r <= 1'b0;
      div_cnt_r   <= '0;
    end else begin
      if (cfg_we && (cfg_index == REG_RANDOM_SEED)) lfsr_r <= cfg_data;
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (take) begin
            if (in_last_sample) begin
              // Close the scan and settle the drive command
              index_r     <= '0;
              min_left_r  <= START_MIN;
              min_right_r <= START_MIN;
              blocked_r   <= 1'b0;
              close_r     <= 1'b0;
              state_r     <= S_FIN;
              if (avoid && (counter_r == 9'd0)) begin
                turn_neg_r <= right_upd < left_upd;
                lfsr_r     <= lfsr_adv;
                div_cnt_r  <= '0;
                state_r    <= S_DIV;
              end else if (avoid) begin
                counter_r <= counter_r - 9'd1;
              end
            end else begin
              if (index_r < INDEX_MAX) index_r <= index_r + 11'd1;
              min_left_r  <= left_upd;
              min_right_r <= right_upd;
              blocked_r   <= blk_upd;
              close_r     <= cls_upd;
            end
          end
        end
        S_DIV: begin
          // One remainder bit per cycle
          div_cnt_r <= div_cnt_r + 4'd1;
          if (div_cnt_r == DIV_LAST) begin
            state_r <= S_FIN;
            if (avoid_time_r == 8'd0) begin
              counter_r <= '0;
            end else if (trial >= {1'b0, avoid_time_r}) begin
              counter_r <= 9'(trial - {1'b0, avoid_time_r}) + {1'b0, avoid_time_r};
            end else begin
              counter_r <= trial + {1'b0, avoid_time_r};
            end
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Divider datapath and pending result
  always_ff @(posedge clk) begin
    if (take && in_last_sample) begin
      res_min_left_r  <= left_upd;
      res_min_right_r <= right_upd;
      res_blocked_r   <= blk_upd;
      res_close_r     <= cls_upd;
      res_lin_r       <= avoid ? 16'd0 : move_rate_r;
      res_ang_r       <= '0;
      res_mode_r      <= MODE_FORWARD;
      dvd_r           <= lfsr_adv;
      rem_r           <= '0;
      if (avoid && (counter_r == 9'd0)) begin
        res_mode_r <= MODE_START;
      end else if (avoid) begin
        res_mode_r <= MODE_TURN;
        res_ang_r  <= turn_neg_r ? -$signed({1'b0, turn_rate_r})
                                 : $signed({1'b0, turn_rate_r});
      end
    end else if (state_r == S_DIV) begin
      dvd_r <= {dvd_r[14:0], 1'b0};
      if ((avoid_time_r != 8'd0) && (trial >= {1'b0, avoid_time_r})) begin
        rem_r <= 8'(trial - {1'b0, avoid_time_r});
      end else begin
        rem_r <= trial[7:0];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if ((state_r == S_FIN) && out_free) begin
      out_linear_speed <= res_lin_r;
      out_angular_rate <= res_ang_r;
      out_drive_mode   <= res_mode_r;
      out_min_left     <= res_min_left_r;
      out_min_right    <= res_min_right_r;
      out_blocked      <= res_blocked_r;
      out_too_close    <= res_close_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule
